// ===== rtl/serial_sram_transaction_sequencer_macros.svh =====
// ----------------------------------------------------------------------------
// Serial SRAM sequencer assertion macros
// Shorthands for clocked assertions with reset disable.
// ----------------------------------------------------------------------------
`ifndef SERIAL_SRAM_TRANSACTION_SEQUENCER_MACROS_SVH
`define SERIAL_SRAM_TRANSACTION_SEQUENCER_MACROS_SVH

// same-cycle implication
`define SSTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SSTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ssts_pkg.sv =====
// ----------------------------------------------------------------------------
// ssts_pkg
// Types, codes and constants shared by the serial SRAM sequencer modules.
// ----------------------------------------------------------------------------
package ssts_pkg;

    // request / input word codes
    localparam logic [2:0] CMD_READ  = 3'd0;
    localparam logic [2:0] CMD_FAST  = 3'd1;
    localparam logic [2:0] CMD_WRITE = 3'd2;
    localparam logic [2:0] CMD_WMODE = 3'd3;
    localparam logic [2:0] CMD_RMODE = 3'd4;
    localparam logic [2:0] CMD_RXB   = 3'd5;

    // result kinds
    localparam logic [1:0] KIND_TX   = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_BUSY = 2'd2;

    // active transaction codes (request code plus one)
    localparam logic [2:0] OP_IDLE  = 3'd0;
    localparam logic [2:0] OP_READ  = 3'd1;
    localparam logic [2:0] OP_FAST  = 3'd2;
    localparam logic [2:0] OP_RMODE = 3'd5;

    // device opcodes and fixed bytes
    localparam logic [7:0] OPC_READ  = 8'h03;
    localparam logic [7:0] OPC_FAST  = 8'h0B;
    localparam logic [7:0] OPC_WRITE = 8'h02;
    localparam logic [7:0] OPC_WRMR  = 8'h01;
    localparam logic [7:0] OPC_RDMR  = 8'h05;
    localparam logic [7:0] MODE_SEQ  = 8'h40;
    localparam logic [7:0] FILL_B4   = 8'h11;
    localparam logic [7:0] FILL_B5   = 8'h12;
    localparam logic [7:0] FILL_B6   = 8'h13;
    localparam logic [7:0] FILL_B7   = 8'h14;

    localparam int RUN_LEN = 9;
    localparam int RUN_IW  = 4;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [23:0] address;
        logic [31:0] write_data;
        logic [7:0]  rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]                     kind;
        logic [31:0]                    data;
        logic [RUN_IW-1:0]              last_idx;
        logic [RUN_LEN-1:0][7:0]        bytes;
    } t_run_desc;

endpackage

// ===== rtl/ssts_in_reg.sv =====
// ----------------------------------------------------------------------------
// ssts_in_reg
// Input register: holds one accepted word until the core takes it.
// ----------------------------------------------------------------------------
module ssts_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  ssts_pkg::t_in_item i_item,
    output logic              o_valid,
    output ssts_pkg::t_in_item o_item,
    input  logic              i_take
);
    import ssts_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// ===== rtl/ssts_core.sv =====
// ----------------------------------------------------------------------------
// ssts_core
// Transaction state and run builder: decodes one word per cycle unless its
// result must wait; it updates the transaction state and feeds the emitter.
// ----------------------------------------------------------------------------
module ssts_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_wdata,
    input  logic               i_in_valid,
    input  ssts_pkg::t_in_item i_item,
    output logic               o_take,
    input  logic               i_emit_free,
    output logic               o_load,
    output ssts_pkg::t_run_desc o_desc
);
    import ssts_pkg::*;

    logic [7:0]  r_mode_byte;
    logic [2:0]  r_op,    n_op;
    logic [3:0]  r_pend,  n_pend;
    logic [31:0] r_shift, n_shift;

    t_run_desc   desc;
    logic        has_res;
    logic [31:0] shifted;
    logic [3:0]  dec;

    always_comb begin
        n_op    = r_op;
        n_pend  = r_pend;
        n_shift = r_shift;
        desc    = '0;
        has_res = 1'b0;
        shifted = {r_shift[23:0], i_item.rx_byte};
        dec     = (r_pend != 4'd0) ? r_pend - 4'd1 : 4'd0;
        if (i_in_valid) begin
            unique case (i_item.cmd)
                CMD_RXB: begin
                    // drop returned bytes while idle
                    if (r_op != OP_IDLE) begin
                        n_shift = shifted;
                        n_pend  = dec;
                        if (dec == 4'd0) begin
                            n_op          = OP_IDLE;
                            has_res       = 1'b1;
                            desc.kind     = KIND_DONE;
                            if (r_op == OP_READ || r_op == OP_FAST) begin
                                desc.data = shifted;
                            end else if (r_op == OP_RMODE) begin
                                desc.data = {16'd0, shifted[15:0]};
                            end
                        end
                    end
                end
                CMD_READ, CMD_FAST, CMD_WRITE, CMD_WMODE, CMD_RMODE: begin
                    has_res = 1'b1;
                    if (r_op != OP_IDLE) begin
                        desc.kind = KIND_BUSY;
                    end else begin
                        desc.kind = KIND_TX;
                        n_op      = i_item.cmd + 3'd1;
                        n_shift   = '0;
                        desc.bytes[1] = i_item.address[23:16];
                        desc.bytes[2] = i_item.address[15:8];
                        desc.bytes[3] = i_item.address[7:0];
                        case (i_item.cmd)
                            CMD_READ: begin
                                desc.bytes[0] = OPC_READ;
                                desc.bytes[4] = FILL_B4;
                                desc.bytes[5] = FILL_B5;
                                desc.bytes[6] = FILL_B6;
                                desc.bytes[7] = FILL_B7;
                                desc.last_idx = 4'd7;
                            end
                            CMD_FAST: begin
                                desc.bytes[0] = OPC_FAST;
                                desc.last_idx = 4'd8;
                            end
                            CMD_WRITE: begin
                                desc.bytes[0] = OPC_WRITE;
                                desc.bytes[4] = i_item.write_data[31:24];
                                desc.bytes[5] = i_item.write_data[23:16];
                                desc.bytes[6] = i_item.write_data[15:8];
                                desc.bytes[7] = i_item.write_data[7:0];
                                desc.last_idx = 4'd7;
                            end
                            CMD_WMODE: begin
                                desc.bytes[0] = OPC_WRMR;
                                desc.bytes[1] = r_mode_byte;
                                desc.bytes[2] = FILL_B7;
                                desc.bytes[3] = 8'h00;
                                desc.last_idx = 4'd2;
                            end
                            default: begin
                                desc.bytes[0] = OPC_RDMR;
                                desc.bytes[1] = 8'h00;
                                desc.bytes[2] = 8'h00;
                                desc.bytes[3] = 8'h00;
                                desc.last_idx = 4'd2;
                            end
                        endcase
                        n_pend = desc.last_idx + 4'd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // words with no result never wait for the emitter
    assign o_take = i_in_valid && (!has_res || i_emit_free);
    assign o_load = o_take && has_res;
    assign o_desc = desc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_byte <= MODE_SEQ;
            r_op        <= OP_IDLE;
            r_pend      <= 4'd0;
            r_shift     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_mode_byte <= i_cfg_wdata;
            end
            if (o_take) begin
                r_op    <= n_op;
                r_pend  <= n_pend;
                r_shift <= n_shift;
            end
        end
    end

endmodule

// ===== rtl/ssts_emit.sv =====
// ----------------------------------------------------------------------------
// ssts_emit
// Result emitter: holds one run and hands out its words one per ready cycle.
// ----------------------------------------------------------------------------
module ssts_emit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  ssts_pkg::t_run_desc i_desc,
    output logic                o_free,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [1:0]          o_kind,
    output logic [7:0]          o_tx_byte,
    output logic [31:0]         o_read_data,
    output logic                o_last
);
    import ssts_pkg::*;

    logic                 r_valid;
    t_run_desc            r_desc;
    logic [RUN_IW-1:0]    r_idx;

    assign o_valid     = r_valid;
    assign o_kind      = r_desc.kind;
    assign o_tx_byte   = (r_desc.kind == KIND_TX) ? r_desc.bytes[r_idx] : 8'h00;
    assign o_read_data = r_desc.data;
    assign o_last      = (r_idx == r_desc.last_idx);
    assign o_free      = !r_valid || (i_ready && o_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (r_valid && i_ready) begin
            // advance through the run, drop it after the last word
            if (o_last) begin
                r_valid <= 1'b0;
            end
            r_idx <= r_idx + RUN_IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_desc <= i_desc;
        end
    end

endmodule

// ===== rtl/serial_sram_transaction_sequencer.sv =====
// ----------------------------------------------------------------------------
// serial_sram_transaction_sequencer
// Frames serial SRAM transactions above a byte-wide SPI shifter.
// ----------------------------------------------------------------------------
// A request word (read, fast read, write, write mode, read mode) produces its
// transmit run of 8, 9, 8, 3 or 3 words, one per cycle while the output is
// ready, from a run register walked by a byte counter; a returned-byte word
// ends the transaction with a single done word after the expected count.
// A request while busy gives one reject word. One input word is taken per
// cycle whenever the input register is free, and the input register holds
// the next word while a run drains.
module serial_sram_transaction_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // address[23:0], write_data[55:24], rx_byte[63:56]
    input  logic [2:0]  s_axis_tuser,  // cmd[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // tx_byte[7:0], read_data[39:8]
    output logic [1:0]  m_axis_tuser,  // kind[1:0]
    output logic        m_axis_tlast
);
    import ssts_pkg::*;

    t_in_item  in_item, reg_item;
    t_run_desc desc;
    logic      reg_valid;
    logic      take;
    logic      emit_free;
    logic      load;
    logic [7:0]  tx_byte;
    logic [31:0] read_data;

    assign in_item.cmd        = s_axis_tuser;
    assign in_item.address    = s_axis_tdata[23:0];
    assign in_item.write_data = s_axis_tdata[55:24];
    assign in_item.rx_byte    = s_axis_tdata[63:56];

    ssts_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .o_valid (reg_valid),
        .o_item  (reg_item),
        .i_take  (take)
    );

    ssts_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (reg_valid),
        .i_item      (reg_item),
        .o_take      (take),
        .i_emit_free (emit_free),
        .o_load      (load),
        .o_desc      (desc)
    );

    ssts_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_desc      (desc),
        .o_free      (emit_free),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_kind      (m_axis_tuser),
        .o_tx_byte   (tx_byte),
        .o_read_data (read_data),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {read_data, tx_byte};

endmodule

// ===== rtl/ssts_checker.sv =====
// ----------------------------------------------------------------------------
// ssts_checker
// Port-level checks on the sequencer result stream.
// ----------------------------------------------------------------------------
`include "serial_sram_transaction_sequencer_macros.svh"

module ssts_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    import ssts_pkg::*;

    // hold a stalled word
    `SSTS_ASSERT_NEXT(a_hold_valid, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "valid dropped while stalled")
    // done and reject words stand alone
    `SSTS_ASSERT_NOW(a_single_last, m_axis_tvalid && m_axis_tuser != KIND_TX, m_axis_tlast, "done or reject word not last")
    `SSTS_ASSERT_NOW(a_tx_zero, m_axis_tvalid && m_axis_tuser != KIND_TX, m_axis_tdata[7:0] == 8'h00, "tx byte set outside transmit")
    `SSTS_ASSERT_NOW(a_data_zero, m_axis_tvalid && (m_axis_tuser == KIND_TX || m_axis_tuser == KIND_BUSY), m_axis_tdata[39:8] == 32'd0, "read data set outside done")

endmodule

bind serial_sram_transaction_sequencer ssts_checker u_ssts_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
